@@ src/nearest_ray_sphere_hit_unit_assert.svh @@
// assertion macros for the nearest ray-sphere hit unit
`ifndef NEAREST_RAY_SPHERE_HIT_UNIT_ASSERT_SVH
`define NEAREST_RAY_SPHERE_HIT_UNIT_ASSERT_SVH

// same-cycle implication
`define NRSH_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define NRSH_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ src/nrsh_pkg.sv @@
// types and constants of the nearest ray-sphere hit unit
package nrsh_pkg;

  localparam int unsigned MAX_SPHERES = 65536;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned ACC_W       = 100;
  localparam int unsigned B_W         = 49;
  localparam int unsigned TQ_W        = 50;
  localparam int unsigned W_W         = 33;
  localparam int unsigned R_W         = 32;
  localparam int unsigned SQ_STEPS    = 32;
  localparam int unsigned REM_W       = 35;
  localparam int unsigned FRAC_SHIFT  = 28;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SPHERES - 1);

  typedef enum logic [2:0] {
    REG_OX    = 3'd0,
    REG_OY    = 3'd1,
    REG_OZ    = 3'd2,
    REG_DX    = 3'd3,
    REG_DY    = 3'd4,
    REG_DZ    = 3'd5,
    REG_SCALE = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIST,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    S_R,
    S_DX,
    S_DY,
    S_DZ,
    S_WX,
    S_WY,
    S_WZ,
    S_TSQ,
    S_RSQ
  } step_e;

endpackage

@@ src/nearest_ray_sphere_hit_unit.sv @@
// nearest ray-sphere hit unit: bit-serial datapath and sequencer
//
// One sphere is taken per transaction while the unit is idle. All products go
// through one shift-add multiplier that retires one multiplier bit per cycle
// and stops as soon as the remaining multiplier bits are zero, followed by a
// 32-step digit-by-digit square root. A hidden sphere skips the datapath; a
// sphere behind the origin stops after the dot product; a full test runs the
// scaled radius, the dot product, the squared offset, the squared projection,
// the squared radius and the root, in that order. The multiplier sets the
// rate. The result of a set leaves through an output register, so the next
// set starts while it waits.
`include "nearest_ray_sphere_hit_unit_assert.svh"

module nearest_ray_sphere_hit_unit
  import nrsh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, center_z, sphere_radius
  input  logic [111:0] s_axis_tdata,
  // visible
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_found, hit_index, hit_distance, zero pad
  output logic [55:0]  m_axis_tdata
);

  logic signed [31:0] ox_q, oy_q, oz_q;
  logic signed [15:0] dx_q, dy_q, dz_q;
  logic [15:0]        scale_q;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0]        a_q, a_d;
  logic [B_W-1:0]          b_q, b_d;
  logic                    neg_q, neg_d;

  logic signed [W_W-1:0]  wx_q, wy_q, wz_q, wx_d, wy_d, wz_d;
  logic                   last_q, last_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic signed [TQ_W-1:0] tq_q, tq_d;
  logic [R_W-1:0]         r_q, r_d;
  logic [31:0]            root_q, root_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [4:0]             sq_cnt_q, sq_cnt_d;
  logic                   cand_q, cand_d;
  logic signed [31:0]     e_q, e_d;

  logic [IDX_W-1:0]   count_q, count_d;
  logic               have_q, have_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic signed [31:0] best_dist_q, best_dist_d;

  logic               out_valid_q, out_valid_d;
  logic               out_hit_q, out_hit_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [31:0]        out_dist_q, out_dist_d;

  logic                    in_acc;
  logic                    slot_free;
  logic signed [ACC_W-1:0] acc_step;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;
  logic signed [35:0]      t_sh;
  logic signed [36:0]      e_full;
  logic                    upd;
  logic [31:0]             mag_wx, mag_wy, mag_wz;
  logic [16:0]             mag_dx, mag_dy, mag_dz;
  logic signed [W_W-1:0]   cx, cy, cz;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_dist_q, out_idx_q, out_hit_q};

  assign cx = W_W'($signed(s_axis_tdata[31:0])) - W_W'(ox_q);
  assign cy = W_W'($signed(s_axis_tdata[63:32])) - W_W'(oy_q);
  assign cz = W_W'($signed(s_axis_tdata[95:64])) - W_W'(oz_q);

  assign mag_wx = wx_q[W_W-1] ? 32'(-wx_q) : wx_q[31:0];
  assign mag_wy = wy_q[W_W-1] ? 32'(-wy_q) : wy_q[31:0];
  assign mag_wz = wz_q[W_W-1] ? 32'(-wz_q) : wz_q[31:0];
  assign mag_dx = dx_q[15] ? 17'(-17'(dx_q)) : 17'(dx_q);
  assign mag_dy = dy_q[15] ? 17'(-17'(dy_q)) : 17'(dy_q);
  assign mag_dz = dz_q[15] ? 17'(-17'(dz_q)) : 17'(dz_q);

  assign acc_step = !b_q[0] ? acc_q :
                    neg_q   ? acc_q - $signed(a_q) : acc_q + $signed(a_q);

  assign rem_sh = {rem_q[REM_W-3:0], acc_q[91:90]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign t_sh   = 36'(tq_q >>> 14);
  assign e_full = 37'(t_sh) - $signed({5'd0, root_q});

  assign upd = cand_q && (!have_q || (e_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      dz_q    <= -16'sd16384;
      scale_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_OX:    ox_q    <= cfg_wdata_i;
        REG_OY:    oy_q    <= cfg_wdata_i;
        REG_OZ:    oz_q    <= cfg_wdata_i;
        REG_DX:    dx_q    <= cfg_wdata_i[15:0];
        REG_DY:    dy_q    <= cfg_wdata_i[15:0];
        REG_DZ:    dz_q    <= cfg_wdata_i[15:0];
        REG_SCALE: scale_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_R;
      sq_cnt_q    <= '0;
      count_q     <= '0;
      have_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sq_cnt_q    <= sq_cnt_d;
      count_q     <= count_d;
      have_q      <= have_d;
      best_idx_q  <= best_idx_d;
      best_dist_q <= best_dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    a_q      <= a_d;
    b_q      <= b_d;
    neg_q    <= neg_d;
    wx_q     <= wx_d;
    wy_q     <= wy_d;
    wz_q     <= wz_d;
    last_q   <= last_d;
    idx_q    <= idx_d;
    tq_q     <= tq_d;
    r_q      <= r_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
    cand_q   <= cand_d;
    e_q      <= e_d;
    out_hit_q  <= out_hit_d;
    out_idx_q  <= out_idx_d;
    out_dist_q <= out_dist_d;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    acc_d       = acc_q;
    a_d         = a_q;
    b_d         = b_q;
    neg_d       = neg_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    wz_d        = wz_q;
    last_d      = last_q;
    idx_d       = idx_q;
    tq_d        = tq_q;
    r_d         = r_q;
    root_d      = root_q;
    rem_d       = rem_q;
    sq_cnt_d    = sq_cnt_q;
    cand_d      = cand_q;
    e_d         = e_q;
    count_d     = count_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hit_d   = out_hit_q;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wx_d    = cx;
          wy_d    = cy;
          wz_d    = cz;
          last_d  = s_axis_tlast;
          idx_d   = count_q;
          if (count_q != IDX_LAST) count_d = count_q + 1'b1;
          cand_d  = 1'b0;
          acc_d   = '0;
          a_d     = ACC_W'(s_axis_tdata[111:96]);
          b_d     = B_W'(scale_q);
          neg_d   = 1'b0;
          step_d  = S_R;
          state_d = s_axis_tuser ? ST_MUL : ST_DONE;
        end
      end

      ST_MUL: begin
        if (b_q != '0) begin
          acc_d = acc_step;
          a_d   = a_q << 1;
          b_d   = b_q >> 1;
        end else begin
          neg_d = 1'b0;
          case (step_q)
            S_R: begin
              r_d    = acc_q[R_W-1:0];
              acc_d  = '0;
              a_d    = ACC_W'(mag_wx);
              b_d    = B_W'(mag_dx);
              neg_d  = wx_q[W_W-1] ^ dx_q[15];
              step_d = S_DX;
            end
            S_DX: begin
              a_d    = ACC_W'(mag_wy);
              b_d    = B_W'(mag_dy);
              neg_d  = wy_q[W_W-1] ^ dy_q[15];
              step_d = S_DY;
            end
            S_DY: begin
              a_d    = ACC_W'(mag_wz);
              b_d    = B_W'(mag_dz);
              neg_d  = wz_q[W_W-1] ^ dz_q[15];
              step_d = S_DZ;
            end
            S_DZ: begin
              tq_d = acc_q[TQ_W-1:0];
              if (acc_q <= 0) begin
                state_d = ST_DONE;
              end else begin
                acc_d  = '0;
                a_d    = ACC_W'(mag_wx);
                b_d    = B_W'(mag_wx);
                step_d = S_WX;
              end
            end
            S_WX: begin
              a_d    = ACC_W'(mag_wy);
              b_d    = B_W'(mag_wy);
              step_d = S_WY;
            end
            S_WY: begin
              a_d    = ACC_W'(mag_wz);
              b_d    = B_W'(mag_wz);
              step_d = S_WZ;
            end
            S_WZ: begin
              acc_d  = acc_q <<< FRAC_SHIFT;
              a_d    = ACC_W'(tq_q[B_W-1:0]);
              b_d    = tq_q[B_W-1:0];
              neg_d  = 1'b1;
              step_d = S_TSQ;
            end
            S_TSQ: begin
              // start from minus the clamped squared miss distance
              acc_d  = (acc_q < 0) ? '0 : -acc_q;
              a_d    = ACC_W'(r_q) << FRAC_SHIFT;
              b_d    = B_W'(r_q);
              step_d = S_RSQ;
            end
            S_RSQ: begin
              if (acc_q <= 0) begin
                state_d = ST_DONE;
              end else begin
                root_d   = '0;
                rem_d    = '0;
                sq_cnt_d = '0;
                state_d  = ST_SQRT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_SQRT: begin
        acc_d    = acc_q <<< 2;
        sq_cnt_d = sq_cnt_q + 1'b1;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[30:0], 1'b0};
        end
        if (sq_cnt_q == 5'(SQ_STEPS - 1)) state_d = ST_DIST;
      end

      ST_DIST: begin
        cand_d = 1'b1;
        if (e_full > 37'sd2147483647) begin
          e_d = 32'sh7fffffff;
        end else if (e_full < -37'sd2147483648) begin
          e_d = 32'sh80000000;
        end else begin
          e_d = e_full[31:0];
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (last_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_hit_d   = have_q || cand_q;
            out_idx_d   = upd ? idx_q : best_idx_q;
            out_dist_d  = upd ? e_q : best_dist_q;
            count_d     = '0;
            have_d      = 1'b0;
            best_idx_d  = '0;
            best_dist_d = '0;
            state_d     = ST_IDLE;
          end
        end else begin
          have_d = have_q || cand_q;
          if (upd) begin
            best_idx_d  = idx_q;
            best_dist_d = e_q;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  `NRSH_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE,
                    "accepted transaction did not start work")
  `NRSH_ASSERT_NOW(a_miss_is_zero, m_axis_tvalid && !m_axis_tdata[0],
                   m_axis_tdata[48:1] == '0, "miss result carries nonzero fields")
  `NRSH_ASSERT_NEXT(a_set_clears,
                    state_q == ST_DONE && last_q && slot_free,
                    count_q == '0 && !have_q && m_axis_tvalid,
                    "end of set did not report and clear")
  `NRSH_ASSERT_NOW(a_sqrt_root_bound, state_q == ST_SQRT,
                   step_q == S_RSQ, "root started outside the radius step")

endmodule
